>>> hdl/dps_pkg.sv
// dps_pkg: shared types, codes and reset values for the display page sequencer.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package dps_pkg;

  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned PageW     = 8;

  typedef enum logic [1:0] {
    MODE_ROTATE = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_HOLD   = 2'd2,
    MODE_FULL   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_SLEEP = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [CfgIndexW-1:0] CFG_ROTATE_COUNT       = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_KEY_COUNT          = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_ROTATE_TIME        = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_KEY_TIME           = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_KEY_TIME_UNPOWERED = 3'd4;

  localparam logic [CfgDataW-1:0] RST_ROTATE_COUNT       = 8'd4;
  localparam logic [CfgDataW-1:0] RST_KEY_COUNT          = 8'd4;
  localparam logic [CfgDataW-1:0] RST_ROTATE_TIME        = 8'd5;
  localparam logic [CfgDataW-1:0] RST_KEY_TIME           = 8'd5;
  localparam logic [CfgDataW-1:0] RST_KEY_TIME_UNPOWERED = 8'd5;

  typedef struct packed {
    logic [1:0] func;
    logic       power_off;
    logic       page_is_clock;
  } in_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PageW-1:0] page_index;
    logic             refresh;
    logic             stay_awake;
  } out_t;

  typedef struct packed {
    logic [CfgDataW-1:0] rotate_count;
    logic [CfgDataW-1:0] key_count;
    logic [CfgDataW-1:0] rotate_time;
    logic [CfgDataW-1:0] key_time;
    logic [CfgDataW-1:0] key_time_unpowered;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       countdown;
    logic [PageW-1:0] page_idx;
  } state_t;

  function automatic logic [PageW-1:0] next_page(input logic [PageW-1:0] idx,
                                                 input logic [CfgDataW-1:0] count);
    logic [PageW:0] n;
    n = {1'b0, idx} + {{PageW{1'b0}}, 1'b1};
    if (n >= {1'b0, count}) begin
      return '0;
    end
    return n[PageW-1:0];
  endfunction

endpackage

>>> hdl/dps_cfg.sv
// dps_cfg: configuration register bank, written through a plain write port.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dps_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dps_pkg::CfgDataW-1:0]  cfg_wdata,
  output dps_pkg::cfg_t                 cfg
);
  import dps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_count       <= RST_ROTATE_COUNT;
      cfg_r.key_count          <= RST_KEY_COUNT;
      cfg_r.rotate_time        <= RST_ROTATE_TIME;
      cfg_r.key_time           <= RST_KEY_TIME;
      cfg_r.key_time_unpowered <= RST_KEY_TIME_UNPOWERED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROTATE_COUNT:       cfg_r.rotate_count       <= cfg_wdata;
        CFG_KEY_COUNT:          cfg_r.key_count          <= cfg_wdata;
        CFG_ROTATE_TIME:        cfg_r.rotate_time        <= cfg_wdata;
        CFG_KEY_TIME:           cfg_r.key_time           <= cfg_wdata;
        CFG_KEY_TIME_UNPOWERED: cfg_r.key_time_unpowered <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/dps_step.sv
// dps_step: next-state and result logic for one event.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_step (
  input  dps_pkg::cfg_t   cfg,
  input  dps_pkg::state_t cur,
  input  dps_pkg::in_t    evt,
  output dps_pkg::state_t nxt,
  output dps_pkg::out_t   res
);
  import dps_pkg::*;

  logic [7:0]       cd_dec;
  logic [CfgDataW-1:0] kc;
  logic [PageW:0]   rot_n;
  logic             rot_wrap;
  logic             refresh;
  logic             awake;

  always_comb begin
    cd_dec   = (cur.countdown != 8'd0) ? cur.countdown - 8'd1 : 8'd0;
    kc       = (cfg.key_count == '0) ? CfgDataW'(1) : cfg.key_count;
    rot_n    = {1'b0, cur.page_idx} + {{PageW{1'b0}}, 1'b1};
    rot_wrap = rot_n >= {1'b0, cfg.rotate_count};
    nxt      = cur;
    refresh  = 1'b0;
    awake    = 1'b0;
    case (func_t'(evt.func))
      FUNC_TICK: begin
        refresh       = 1'b1;
        nxt.countdown = cd_dec;
        if (cd_dec == 8'd0) begin
          if (cur.mode == MODE_ROTATE) begin
            nxt.countdown = cfg.rotate_time;
            nxt.page_idx  = rot_wrap ? '0 : rot_n[PageW-1:0];
          end else if (cur.mode != MODE_HOLD) begin
            nxt.countdown = cfg.rotate_time;
            nxt.mode      = MODE_ROTATE;
            nxt.page_idx  = '0;
          end
        end
      end
      FUNC_KEY: begin
        refresh       = 1'b1;
        nxt.countdown = evt.power_off ? cfg.key_time_unpowered : cfg.key_time;
        if (cur.mode != MODE_KEY) begin
          nxt.mode     = MODE_KEY;
          nxt.page_idx = '0;
        end else begin
          nxt.page_idx = next_page(cur.page_idx, kc);
        end
      end
      FUNC_SLEEP: begin
        nxt.countdown = cd_dec;
        if (cd_dec != 8'd0) begin
          refresh = evt.page_is_clock;
          awake   = 1'b1;
        end else if (cur.mode == MODE_ROTATE) begin
          nxt.countdown = cfg.rotate_time;
          refresh       = 1'b1;
          nxt.page_idx  = rot_wrap ? '0 : rot_n[PageW-1:0];
          awake         = !rot_wrap;
        end
      end
      default: ;
    endcase
    res.mode       = nxt.mode;
    res.page_index = nxt.page_idx;
    res.refresh    = refresh;
    res.stay_awake = awake;
  end

endmodule

>>> hdl/display_page_sequencer_unit.sv
// display_page_sequencer_unit: top level of the display page sequencer.
// Depends on dps_pkg, dps_cfg and dps_step.
//
//   channel | ports                          | transfer
//   input   | in_valid, in_ready, in_data    | valid & ready at clk rise
//   result  | out_valid, out_ready, out_data | valid & ready at clk rise
//   config  | cfg_we, cfg_index, cfg_wdata   | cfg_we at clk rise, no wait
//
// One event per cycle sustained while out_ready stays high; each event passes
// through the input register, then the result register.
// State update happens as an event moves from the input register to the
// result register, so back-to-back events see each other's effects.
// Synchronous active-low reset: mode full, countdown and page index zero.
// A stalled result holds the input register; in_ready drops only when both
// stages are full and out_ready is low.
`timescale 1ns / 1ps

module display_page_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dps_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dps_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [dps_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dps_pkg::CfgDataW-1:0]  cfg_wdata
);
  import dps_pkg::*;

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  out_t   res_nxt;
  in_t    in_data_r;
  logic   in_valid_r;
  out_t   out_data_r;
  logic   out_valid_r;
  logic   advance;

  dps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dps_step u_step (
    .cfg (cfg),
    .cur (state_r),
    .evt (in_data_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: MODE_FULL, countdown: 8'd0, page_idx: '0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
